// ===== sv/msp_pkg.sv =====
// Shared constants and control/status types for the min-factor split path block.
package msp_pkg;

    localparam int MAX_POSITIONS_DEF = 64;

    localparam int LEN_W       = 7;
    localparam int SEG_START_W = 6;
    localparam int SEG_END_W   = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    // Controller to datapath commands, at most one step per cycle
    typedef struct packed {
        logic relax_rd;   // capture item, read both edge targets
        logic relax_w1;   // relax edge to pos+1
        logic relax_w2;   // relax edge to pos+len, advance position
        logic bt_init;    // start backtrack at current position
        logic bt_rd;      // read predecessor of cursor
        logic bt_push;    // push segment, step cursor to predecessor
        logic pop_rd;     // read top of segment stack
        logic load_out;   // load output register
        logic out_done;   // output request taken
        logic clear_all;  // clear node valid bits, position and distance
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pos_zero;
        logic pos_full;
        logic pred_zero;
        logic sp_zero;
        logic out_valid;
    } sts_t;

endpackage

// ===== sv/msp_datapath.sv =====
// Datapath: node memory (distance, predecessor), segment stack and output register.
module msp_datapath #(
    parameter int MAX_POSITIONS = msp_pkg::MAX_POSITIONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  msp_pkg::cmd_t                    cmd,
    input  logic [msp_pkg::LEN_W-1:0]        factor_length,
    output msp_pkg::sts_t                    sts,
    output logic [msp_pkg::SEG_START_W-1:0]  seg_start,
    output logic [msp_pkg::SEG_END_W-1:0]    seg_end,
    output logic                             last_seg
);
    import msp_pkg::*;

    localparam int IDX_W   = $clog2(MAX_POSITIONS + 1);
    localparam int DIST_W  = $clog2(MAX_POSITIONS + 2);
    localparam int SUM_W   = $clog2(MAX_POSITIONS + 128);
    localparam int ENT_W   = IDX_W + DIST_W;
    localparam int STK_AW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam logic [DIST_W-1:0] UNREACHED = DIST_W'(MAX_POSITIONS + 1);

    // node memory: {pred, dist}; entry 0 is never written or read
    logic [ENT_W-1:0]       node_mem [0:MAX_POSITIONS];
    logic [MAX_POSITIONS:0] valid_reg;
    logic [2*IDX_W-1:0]     stack_mem [0:MAX_POSITIONS-1];

    logic [IDX_W-1:0]  pos_reg;
    logic [DIST_W-1:0] cur_dist_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  sp_reg;
    logic              out_valid_reg;

    logic [IDX_W-1:0]  t2_reg;
    logic              t2_ok_reg;
    logic [ENT_W-1:0]  rda_data_reg;
    logic [ENT_W-1:0]  rdb_data_reg;
    logic              rda_vld_reg;
    logic              rdb_vld_reg;
    logic [2*IDX_W-1:0] stk_rd_reg;
    logic [SEG_START_W-1:0] seg_start_reg;
    logic [SEG_END_W-1:0]   seg_end_reg;
    logic                   last_seg_reg;

    logic [SUM_W-1:0]  sum;
    logic              t2_ok_next;
    logic [IDX_W-1:0]  t1;
    logic [IDX_W-1:0]  rda_addr;
    logic [IDX_W-1:0]  rdb_addr;
    logic              rd_en;
    logic [DIST_W-1:0] a_dist;
    logic [DIST_W-1:0] b_dist;
    logic [IDX_W-1:0]  a_pred;
    logic [DIST_W-1:0] cand;
    logic [DIST_W-1:0] min1;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [IDX_W-1:0]  sp_dec;
    logic [IDX_W+SEG_START_W-1:0] start_wide;
    logic [IDX_W+SEG_END_W-1:0]   end_wide;

    assign sum        = SUM_W'(pos_reg) + SUM_W'(factor_length);
    // length 0 is a self-loop, length 1 duplicates the pos+1 edge
    assign t2_ok_next = (factor_length > LEN_W'(1)) && (sum <= SUM_W'(MAX_POSITIONS));
    assign t1         = pos_reg + IDX_W'(1);
    assign rd_en      = cmd.relax_rd | cmd.bt_rd;
    assign rda_addr   = cmd.bt_rd ? cur_reg : t1;
    assign rdb_addr   = t2_ok_next ? sum[IDX_W-1:0] : t1;

    // unwritten entries read as unreached with predecessor zero
    assign a_dist = rda_vld_reg ? rda_data_reg[DIST_W-1:0] : UNREACHED;
    assign b_dist = rdb_vld_reg ? rdb_data_reg[DIST_W-1:0] : UNREACHED;
    assign a_pred = rda_vld_reg ? rda_data_reg[ENT_W-1:DIST_W] : '0;
    assign cand   = cur_dist_reg + DIST_W'(1);
    assign min1   = (cand < a_dist) ? cand : a_dist;
    assign sp_dec = sp_reg - IDX_W'(1);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = t1;
        wr_data = {pos_reg, cand};
        if (cmd.relax_w1 && (cand < a_dist))
        begin
            wr_en = 1'b1;
        end
        else if (cmd.relax_w2 && t2_ok_reg && (cand < b_dist))
        begin
            wr_en   = 1'b1;
            wr_addr = t2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            pos_reg       <= '0;
            cur_dist_reg  <= '0;
            cur_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.relax_w2)
            begin
                pos_reg      <= t1;
                cur_dist_reg <= min1;
            end
            if (cmd.bt_init)
            begin
                cur_reg <= pos_reg;
                sp_reg  <= '0;
            end
            if (cmd.bt_push)
            begin
                cur_reg <= a_pred;
                sp_reg  <= sp_reg + IDX_W'(1);
            end
            if (cmd.pop_rd)
            begin
                sp_reg <= sp_dec;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.out_done)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear_all)
            begin
                valid_reg    <= '0;
                pos_reg      <= '0;
                cur_dist_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rda_data_reg <= node_mem[rda_addr];
            rdb_data_reg <= node_mem[rdb_addr];
            rda_vld_reg  <= valid_reg[rda_addr];
            rdb_vld_reg  <= valid_reg[rdb_addr];
        end
        if (cmd.relax_rd)
        begin
            t2_reg    <= sum[IDX_W-1:0];
            t2_ok_reg <= t2_ok_next;
        end
        if (cmd.bt_push)
        begin
            stack_mem[sp_reg[STK_AW-1:0]] <= {a_pred, cur_reg};
        end
        if (cmd.pop_rd)
        begin
            stk_rd_reg <= stack_mem[sp_dec[STK_AW-1:0]];
        end
        if (cmd.load_out)
        begin
            seg_start_reg <= start_wide[SEG_START_W-1:0];
            seg_end_reg   <= end_wide[SEG_END_W-1:0];
            last_seg_reg  <= (sp_reg == '0);
        end
    end

    assign start_wide = {{SEG_START_W{1'b0}}, stk_rd_reg[2*IDX_W-1:IDX_W]};
    assign end_wide   = {{SEG_END_W{1'b0}}, stk_rd_reg[IDX_W-1:0]};

    assign sts.pos_zero  = (pos_reg == '0);
    assign sts.pos_full  = (pos_reg == IDX_W'(MAX_POSITIONS));
    assign sts.pred_zero = (a_pred == '0);
    assign sts.sp_zero   = (sp_reg == '0);
    assign sts.out_valid = out_valid_reg;

    assign seg_start = seg_start_reg;
    assign seg_end   = seg_end_reg;
    assign last_seg  = last_seg_reg;

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_dist_reg <= pos_reg)
        else $error("distance of current position exceeds position");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= IDX_W'(MAX_POSITIONS))
        else $error("segment stack overflow");

    a_pred_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bt_push |-> (a_pred < cur_reg))
        else $error("backtrack predecessor not below cursor");

endmodule

// ===== sv/msp_ctrl.sv =====
// Controller: sequences relaxation, backtracking and segment output.
module msp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    output logic          s_tready,
    input  logic          m_tready,
    input  msp_pkg::sts_t sts,
    output msp_pkg::cmd_t cmd
);
    import msp_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_RELAX1  = 8'b0000_0010,
        ST_RELAX2  = 8'b0000_0100,
        ST_BT_RD   = 8'b0000_1000,
        ST_BT_PUSH = 8'b0001_0000,
        ST_POP     = 8'b0010_0000,
        ST_LOAD    = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!s_tlast)
                    begin
                        // items past the last position are dropped
                        if (!sts.pos_full)
                        begin
                            cmd.relax_rd = 1'b1;
                            state_next   = ST_RELAX1;
                        end
                    end
                    else if (sts.pos_zero)
                    begin
                        cmd.clear_all = 1'b1;
                    end
                    else
                    begin
                        cmd.bt_init = 1'b1;
                        state_next  = ST_BT_RD;
                    end
                end
            end
            ST_RELAX1:
            begin
                cmd.relax_w1 = 1'b1;
                state_next   = ST_RELAX2;
            end
            ST_RELAX2:
            begin
                cmd.relax_w2 = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_BT_RD:
            begin
                cmd.bt_rd  = 1'b1;
                state_next = ST_BT_PUSH;
            end
            ST_BT_PUSH:
            begin
                cmd.bt_push = 1'b1;
                state_next  = sts.pred_zero ? ST_POP : ST_BT_RD;
            end
            ST_POP:
            begin
                cmd.pop_rd = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_out = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    cmd.out_done = 1'b1;
                    if (sts.sp_zero)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        sts.out_valid == (state_reg == ST_OUT))
        else $error("output valid out of step with controller");

endmodule

// ===== sv/min_factor_split_path.sv =====
// Top level: fewest-segment factor split over positions 0..n, streaming in and out.
// Flow: a non-last request is taken in states accept, relax pos+1, relax pos+len; the single
//   write port of the node memory sets this, and no new request is taken until it is done.
// Last request: accept, then backtrack by a read and a push per segment (registered predecessor
//   read), then each segment goes through pop, load and present, plus any m_tready stall.
// Reset: rst_n asynchronous, active low; node valid bits clear at once, no clearing pass.
module min_factor_split_path #(
    parameter int MAX_POSITIONS = msp_pkg::MAX_POSITIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msp_pkg::S_TDATA_W-1:0]   s_tdata,   // [6:0] factor_length
    input  logic                            s_tlast,   // last_item: marks position n
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msp_pkg::M_TDATA_W-1:0]   m_tdata,   // [5:0] seg_start, [12:6] seg_end
    output logic                            m_tlast    // last_seg
);
    import msp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [SEG_START_W-1:0] seg_start;
    logic [SEG_END_W-1:0]   seg_end;
    logic                   last_seg;

    // FSM: one request at a time; relax, then backtrack and emit on the last one
    msp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // node memory with two read ports, segment stack, output register
    msp_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .factor_length (s_tdata[LEN_W-1:0]),
        .sts           (sts),
        .seg_start     (seg_start),
        .seg_end       (seg_end),
        .last_seg      (last_seg)
    );

    assign m_tvalid = sts.out_valid;
    assign m_tdata  = {{(M_TDATA_W - SEG_START_W - SEG_END_W){1'b0}}, seg_end, seg_start};
    assign m_tlast  = last_seg;

endmodule

// ===== test/tb_min_factor_split_path.sv =====
// Testbench for min_factor_split_path: random and directed sequences, checked by a path predictor.
`timescale 1ns / 1ps

module tb_min_factor_split_path;

    import msp_pkg::*;

    localparam int NPOS     = MAX_POSITIONS_DEF;
    localparam int UNSEEN   = NPOS + 1;
    localparam int PHASE_SZ = 140;   // requests per idling phase, about 420 overall

    // One path segment, as carried on the output stream
    typedef struct packed {
        logic [SEG_START_W-1:0] start_pos;
        logic [SEG_END_W-1:0]   end_pos;
        logic                   final_seg;
    } segment_t;

    // Shortest-split predictor plus the queue of segments still to come
    class split_scoreboard;
        int unsigned hops[0:NPOS];      // fewest edges from position 0
        int unsigned from_pos[0:NPOS];  // predecessor on that route
        int unsigned next_pos;
        segment_t    pending_segs[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i <= NPOS; i++)
            begin
                hops[i]     = UNSEEN;
                from_pos[i] = 0;
            end
            hops[0]  = 0;
            next_pos = 0;
        endfunction

        // strict less-than keeps the smallest predecessor on ties
        function void relax_edge(int unsigned src, int unsigned dst);
            if (dst <= src || dst > NPOS)
                return;
            if (hops[src] + 1 < hops[dst])
            begin
                hops[dst]     = hops[src] + 1;
                from_pos[dst] = src;
            end
        endfunction

        function void note_request(logic [LEN_W-1:0] len, logic last);
            int unsigned trail[0:NPOS-1];
            int unsigned cur;
            int unsigned depth;
            int unsigned p;
            int unsigned seg_end;
            segment_t    seg;
            if (!last)
            begin
                // saturated: extra positions are dropped
                if (next_pos >= NPOS)
                    return;
                relax_edge(next_pos, next_pos + 1);
                relax_edge(next_pos, next_pos + len);
                next_pos++;
                return;
            end
            // trace back from n; empty sequence gives nothing
            cur   = next_pos;
            depth = 0;
            while (cur > 0 && depth < NPOS)
            begin
                p            = from_pos[cur];
                trail[depth] = cur;
                depth++;
                if (p >= cur)
                    break;
                cur = p;
            end
            for (int k = 0; k < depth; k++)
            begin
                seg_end       = trail[depth - 1 - k];
                seg.start_pos = SEG_START_W'(from_pos[seg_end]);
                seg.end_pos   = SEG_END_W'(seg_end);
                seg.final_seg = (k + 1 == depth);
                pending_segs.push_back(seg);
            end
            clear();
        endfunction

        function void check_segment(segment_t got);
            segment_t want;
            if (pending_segs.size() == 0)
            begin
                $display("%0t: unexpected segment start=%0d end=%0d last=%0b",
                         $time, got.start_pos, got.end_pos, got.final_seg);
                errors++;
                return;
            end
            want = pending_segs.pop_front();
            if (got.start_pos !== want.start_pos)
            begin
                $display("%0t: seg_start expected %0d got %0d", $time,
                         want.start_pos, got.start_pos);
                errors++;
            end
            if (got.end_pos !== want.end_pos)
            begin
                $display("%0t: seg_end expected %0d got %0d", $time,
                         want.end_pos, got.end_pos);
                errors++;
            end
            if (got.final_seg !== want.final_seg)
            begin
                $display("%0t: last_seg expected %0b got %0b", $time,
                         want.final_seg, got.final_seg);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    split_scoreboard sb;
    int              send_idle;   // percent of cycles the sender holds off
    int              recv_idle;   // percent of cycles the receiver stalls
    int              requests_sent;

    min_factor_split_path uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: stall pattern picked at each falling edge
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Output requests are checked at the edge that accepts them
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_segment({m_tdata[5:0], m_tdata[12:6], m_tlast});
    end

    // Entered and left at a falling edge; valid stays up across back-to-back requests.
    task automatic send_request(input logic [LEN_W-1:0] len, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, len};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(len, last);
        requests_sent++;
        @(negedge clk);
    endtask

    // n positions then the end marker; lengths lean toward edges that land inside
    task automatic run_sequence(input int n, input bit jump_first);
        logic [LEN_W-1:0] len;
        int               reach;
        for (int p = 0; p < n; p++)
        begin
            reach = (n - p + 1 > NPOS) ? NPOS : n - p + 1;
            if (jump_first && p == 0)
                len = LEN_W'(NPOS);
            else
                case ($urandom_range(9))
                    0:       len = '0;
                    1, 2:    len = LEN_W'($urandom_range(NPOS));
                    default: len = LEN_W'($urandom_range(reach, 1));
                endcase
            send_request(len, 1'b0);
        end
        send_request(LEN_W'($urandom_range(NPOS)), 1'b1);
    endtask

    initial
    begin
        int n;
        sb            = new();
        requests_sent = 0;
        send_idle     = 23;
        recv_idle     = 85;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty sequence: end marker at position 0, no segments
        send_request(7'd5, 1'b1);
        // single step, zero-length self-loop
        send_request(7'd0, 1'b0);
        send_request(7'd0, 1'b1);
        // longest jump lands past n
        send_request(LEN_W'(NPOS), 1'b0);
        send_request(7'd127 & 7'd63, 1'b1);
        // tie at position 4: smallest predecessor must win
        send_request(7'd2, 1'b0);
        send_request(7'd3, 1'b0);
        send_request(7'd2, 1'b0);
        send_request(7'd1, 1'b0);
        send_request(LEN_W'(NPOS), 1'b1);
        // all self-loops: unit steps only
        send_request(7'd0, 1'b0);
        send_request(7'd0, 1'b0);
        send_request(7'd0, 1'b0);
        send_request(7'd0, 1'b1);
        // skip over the end, then land exactly on it
        send_request(7'd9, 1'b0);
        send_request(7'd2, 1'b0);
        send_request(7'd1, 1'b0);
        send_request(7'd0, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 23;
                    recv_idle = 85;
                end
                1:
                begin
                    send_idle = 85;
                    recv_idle = 23;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            while (requests_sent < PHASE_SZ * (phase + 1))
            begin
                // now and then a long one that saturates the position count
                if ($urandom_range(19) == 0)
                    run_sequence(int'($urandom_range(NPOS + 6, NPOS - 2)),
                                 1'($urandom_range(1)));
                else
                begin
                    n = int'($urandom_range(14));
                    run_sequence(n, 1'b0);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_segs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/msp_pkg.sv
sv/msp_datapath.sv
sv/msp_ctrl.sv
sv/min_factor_split_path.sv
test/tb_min_factor_split_path.sv
